// ----- rtl/core/rctas_pkg.sv -----
// Package for the remote clock time and alarm setter.
// Holds payload structs, mode, field and key codes, and digit helpers.
// No dependencies; every other file in rtl/core imports it.
package rctas_pkg;

	// Mode codes.
	localparam logic [1:0] MODE_STANDBY = 2'd0;
	localparam logic [1:0] MODE_TIME    = 2'd1;
	localparam logic [1:0] MODE_ALARM   = 2'd2;

	// Field select codes.
	localparam logic [1:0] FIELD_NONE   = 2'd0;
	localparam logic [1:0] FIELD_HOUR   = 2'd1;
	localparam logic [1:0] FIELD_MINUTE = 2'd2;
	localparam logic [1:0] FIELD_SECOND = 2'd3;

	// Remote key codes.
	localparam logic [7:0] KEY_TIME_SET  = 8'h44;
	localparam logic [7:0] KEY_ALARM_SET = 8'h43;
	localparam logic [7:0] KEY_HOUR      = 8'h45;
	localparam logic [7:0] KEY_MINUTE    = 8'h46;
	localparam logic [7:0] KEY_SECOND    = 8'h47;
	localparam logic [7:0] KEY_CANCEL    = 8'h09;
	localparam logic [7:0] KEY_DIGIT_0   = 8'h16;
	localparam logic [7:0] KEY_DIGIT_1   = 8'h0C;
	localparam logic [7:0] KEY_DIGIT_2   = 8'h18;
	localparam logic [7:0] KEY_DIGIT_3   = 8'h5E;
	localparam logic [7:0] KEY_DIGIT_4   = 8'h08;
	localparam logic [7:0] KEY_DIGIT_5   = 8'h1C;
	localparam logic [7:0] KEY_DIGIT_6   = 8'h5A;
	localparam logic [7:0] KEY_DIGIT_7   = 8'h42;
	localparam logic [7:0] KEY_DIGIT_8   = 8'h52;
	localparam logic [7:0] KEY_DIGIT_9   = 8'h4A;

	// Position of the key code inside a remote frame.
	localparam int KEY_LSB = 16;

	// Alarm window after reset.
	localparam logic [5:0] WINDOW_RESET = 6'd2;

	// Input operation codes.
	localparam logic OP_KEY    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [31:0] ir_word;
		logic [4:0]  now_hours;
		logic [5:0]  now_minutes;
		logic [5:0]  now_seconds;
	} in_item_t;

	typedef struct packed {
		logic       time_load;
		logic [6:0] load_hours;
		logic [6:0] load_minutes;
		logic [6:0] load_seconds;
		logic       alarm_fire;
		logic [1:0] mode;
		logic [1:0] field_sel;
		logic       alarm_armed;
		logic [6:0] alarm_hours;
		logic [6:0] alarm_minutes;
		logic [6:0] alarm_seconds;
	} out_item_t;

	// Stored alarm time.
	typedef struct packed {
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
	} alarm_time_t;

	// Key unit view of one step: load values and state after the step.
	typedef struct packed {
		logic        time_load;
		logic [6:0]  load_hours;
		logic [6:0]  load_minutes;
		logic [6:0]  load_seconds;
		logic [1:0]  mode;
		logic [1:0]  field_sel;
		logic        armed;
		alarm_time_t alarm;
	} key_view_t;

	// Decoded digit key.
	typedef struct packed {
		logic       hit;
		logic [3:0] value;
	} digit_t;

	// Maps a key code to its decimal digit.
	function automatic digit_t key_digit(input logic [7:0] key);
		digit_t d;
		d.hit = 1'b1;
		unique case (key)
			KEY_DIGIT_0: d.value = 4'd0;
			KEY_DIGIT_1: d.value = 4'd1;
			KEY_DIGIT_2: d.value = 4'd2;
			KEY_DIGIT_3: d.value = 4'd3;
			KEY_DIGIT_4: d.value = 4'd4;
			KEY_DIGIT_5: d.value = 4'd5;
			KEY_DIGIT_6: d.value = 4'd6;
			KEY_DIGIT_7: d.value = 4'd7;
			KEY_DIGIT_8: d.value = 4'd8;
			KEY_DIGIT_9: d.value = 4'd9;
			default: begin
				d.hit   = 1'b0;
				d.value = 4'd0;
			end
		endcase
		return d;
	endfunction

	// Two-digit slot value tens*10+units, kept to seven bits.
	function automatic logic [6:0] slot_value(input logic [3:0] tens, input logic [3:0] units);
		logic [7:0] t;
		logic [7:0] sum;
		t   = {4'b0000, tens};
		sum = (t << 3) + (t << 1) + {4'b0000, units};
		return sum[6:0];
	endfunction

endpackage

// ----- rtl/core/rctas_keys.sv -----
// Key handling unit: mode, field, digit entry, and stored alarm time.
// Depends on rctas_pkg.
module rctas_keys (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     key_en,
	input  logic                     advance,
	input  logic [7:0]               key,
	output rctas_pkg::key_view_t     view,
	output rctas_pkg::alarm_time_t   alarm_cur
);
	import rctas_pkg::*;

	logic [1:0]  mode_q;
	logic [1:0]  field_q;
	logic [3:0]  tdig_q [6];
	logic [3:0]  adig_q [6];
	logic [2:0]  tpos_q;
	logic [2:0]  apos_q;
	alarm_time_t alarm_q;
	logic        armed_q;

	logic [1:0]  mode_d;
	logic [1:0]  field_d;
	logic [3:0]  tdig_d [6];
	logic [3:0]  adig_d [6];
	logic [2:0]  tpos_d;
	logic [2:0]  apos_d;
	alarm_time_t alarm_d;
	logic        armed_d;
	logic        load_d;
	alarm_time_t load_val;
	digit_t      dig;
	logic [1:0]  slot;

	assign dig  = key_digit(key);
	assign slot = field_q - 2'd1;

	// Next state for one key transfer.
	always_comb begin
		mode_d   = mode_q;
		field_d  = field_q;
		tdig_d   = tdig_q;
		adig_d   = adig_q;
		tpos_d   = tpos_q;
		apos_d   = apos_q;
		alarm_d  = alarm_q;
		armed_d  = armed_q;
		load_d   = 1'b0;
		load_val = '0;
		if (key_en) begin
			case (key) inside
				KEY_TIME_SET: begin
					if (mode_q == MODE_STANDBY) begin
						mode_d  = MODE_TIME;
						field_d = FIELD_HOUR;
						for (int i = 0; i < 6; i++) begin
							tdig_d[i] = 4'd0;
						end
						tpos_d = 3'b000;
					end else if (mode_q == MODE_TIME) begin
						load_d           = 1'b1;
						load_val.hours   = slot_value(tdig_q[0], tdig_q[1]);
						load_val.minutes = slot_value(tdig_q[2], tdig_q[3]);
						load_val.seconds = slot_value(tdig_q[4], tdig_q[5]);
						mode_d           = MODE_STANDBY;
						field_d          = FIELD_NONE;
					end
				end
				KEY_ALARM_SET: begin
					if (mode_q == MODE_STANDBY) begin
						mode_d  = MODE_ALARM;
						field_d = FIELD_HOUR;
						for (int i = 0; i < 6; i++) begin
							adig_d[i] = 4'd0;
						end
						apos_d = 3'b000;
					end else if (mode_q == MODE_ALARM) begin
						alarm_d.hours   = slot_value(adig_q[0], adig_q[1]);
						alarm_d.minutes = slot_value(adig_q[2], adig_q[3]);
						alarm_d.seconds = slot_value(adig_q[4], adig_q[5]);
						mode_d          = MODE_STANDBY;
						armed_d         = 1'b1;
					end
				end
				KEY_HOUR, KEY_MINUTE, KEY_SECOND: begin
					if (mode_q == MODE_TIME || mode_q == MODE_ALARM) begin
						field_d = 2'(key - KEY_TIME_SET);
					end
				end
				default: begin
					if (dig.hit) begin
						// A digit lands at the selected slot's position, which then toggles.
						if ((mode_q == MODE_TIME || mode_q == MODE_ALARM) &&
						    field_q != FIELD_NONE) begin
							for (int s = 0; s < 3; s++) begin
								if (slot == 2'(s)) begin
									if (mode_q == MODE_TIME) begin
										tdig_d[3'(2*s) + 3'(tpos_q[s])] = dig.value;
										tpos_d[s] = ~tpos_q[s];
									end else begin
										adig_d[3'(2*s) + 3'(apos_q[s])] = dig.value;
										apos_d[s] = ~apos_q[s];
									end
								end
							end
						end
					end else if (key == KEY_CANCEL) begin
						// Cancel clears the alarm time in every mode.
						if (mode_q == MODE_TIME || mode_q == MODE_ALARM) begin
							mode_d  = MODE_STANDBY;
							field_d = FIELD_NONE;
							armed_d = 1'b0;
						end
						alarm_d = '0;
					end
				end
			endcase
		end
	end

	// State registers update when a key leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_STANDBY;
			field_q <= FIELD_NONE;
			for (int i = 0; i < 6; i++) begin
				tdig_q[i] <= 4'd0;
				adig_q[i] <= 4'd0;
			end
			tpos_q  <= 3'b000;
			apos_q  <= 3'b000;
			alarm_q <= '0;
			armed_q <= 1'b0;
		end else if (advance && key_en) begin
			mode_q  <= mode_d;
			field_q <= field_d;
			tdig_q  <= tdig_d;
			adig_q  <= adig_d;
			tpos_q  <= tpos_d;
			apos_q  <= apos_d;
			alarm_q <= alarm_d;
			armed_q <= armed_d;
		end
	end

	// Result view shows the state after the step.
	assign view.time_load    = load_d;
	assign view.load_hours   = load_val.hours;
	assign view.load_minutes = load_val.minutes;
	assign view.load_seconds = load_val.seconds;
	assign view.mode         = mode_d;
	assign view.field_sel    = field_d;
	assign view.armed        = armed_d;
	assign view.alarm        = alarm_d;
	assign alarm_cur         = alarm_q;

endmodule

// ----- rtl/core/rctas_match.sv -----
// Alarm match unit: compares a time sample with the stored alarm and holds
// the one-shot fire latch. Depends on rctas_pkg.
module rctas_match (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_en,
	input  logic                   advance,
	input  logic [4:0]             now_hours,
	input  logic [5:0]             now_minutes,
	input  logic [5:0]             now_seconds,
	input  rctas_pkg::alarm_time_t alarm,
	input  logic [5:0]             window,
	output logic                   fire
);
	import rctas_pkg::*;

	logic       fired_q;
	logic [7:0] win_end;
	logic       hit;

	// Seconds must lie in [alarm second, alarm second + window).
	assign win_end = {1'b0, alarm.seconds} + {2'b00, window};
	assign hit = ({2'b00, now_hours} == alarm.hours) &&
	             ({1'b0, now_minutes} == alarm.minutes) &&
	             ({1'b0, now_seconds} >= alarm.seconds) &&
	             ({2'b00, now_seconds} < win_end);
	assign fire = sample_en && hit && !fired_q;

	// The latch is set by the first fire and cleared only by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q <= 1'b0;
		end else if (advance && fire) begin
			fired_q <= 1'b1;
		end
	end

endmodule

// ----- rtl/core/remote_clock_time_alarm_setter.sv -----
// Remote clock time and alarm setter: one input register, one result register.
// Throughput: one item per cycle while out_ready is high; a low out_ready stalls the input register.
// An item is processed as it moves from the input register to the result register;
// ready follows the result register's room through that single stage.
// Reset clears mode, field, digit entry, alarm time, armed and fire flags; window is 2.
// Depends on rctas_pkg, rctas_keys and rctas_match.
module remote_clock_time_alarm_setter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rctas_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rctas_pkg::out_item_t out_data,
	input  logic                 cfg_wr_en,
	input  logic [5:0]           cfg_wr_data
);
	import rctas_pkg::*;

	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   res_q;
	logic        res_valid_q;
	logic [5:0]  window_q;
	logic        advance;
	logic        key_en;
	logic        sample_en;
	key_view_t   view;
	alarm_time_t alarm_cur;
	logic        fire;

	// The item moves on when the result register is empty or being drained.
	assign advance   = valid_s1 && (!res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign key_en    = valid_s1 && (item_s1.op == OP_KEY);
	assign sample_en = valid_s1 && (item_s1.op == OP_SAMPLE);

	// Alarm window register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	rctas_keys u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_en    (key_en),
		.advance   (advance),
		.key       (item_s1.ir_word[KEY_LSB +: 8]),
		.view      (view),
		.alarm_cur (alarm_cur)
	);

	rctas_match u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_en   (sample_en),
		.advance     (advance),
		.now_hours   (item_s1.now_hours),
		.now_minutes (item_s1.now_minutes),
		.now_seconds (item_s1.now_seconds),
		.alarm       (alarm_cur),
		.window      (window_q),
		.fire        (fire)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.time_load     <= view.time_load;
			res_q.load_hours    <= view.load_hours;
			res_q.load_minutes  <= view.load_minutes;
			res_q.load_seconds  <= view.load_seconds;
			res_q.alarm_fire    <= fire;
			res_q.mode          <= view.mode;
			res_q.field_sel     <= view.field_sel;
			res_q.alarm_armed   <= view.armed;
			res_q.alarm_hours   <= view.alarm.hours;
			res_q.alarm_minutes <= view.alarm.minutes;
			res_q.alarm_seconds <= view.alarm.seconds;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

endmodule
